>>> hw/rtl/html_char_reference_decoder_top_defines.svh
// assertion macros for the html character reference decoder
// used by the top level; depends on clk and rst_n in the including scope
`ifndef HTML_CHAR_REFERENCE_DECODER_TOP_DEFINES_SVH
`define HTML_CHAR_REFERENCE_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HCRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HCRD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCRD_ASSERT(lbl, prop, msg)
`define HCRD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/hcrd_pkg.sv
// shared types, constants and name tables of the character reference decoder
// no dependencies
package hcrd_pkg;

  localparam int WINDOW_LEN  = 16;
  localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
  localparam int IDX_W       = $clog2(WINDOW_LEN);
  localparam int NAME_COUNT  = 20;
  localparam int NAME_IDX_W  = $clog2(NAME_COUNT);
  localparam int LIT_MAX     = 3;
  localparam int SEQ_MAX     = LIT_MAX + WINDOW_LEN + 2;
  localparam int SEQ_W       = $clog2(SEQ_MAX + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_XL    = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  localparam logic [31:0] NUM_NBSP   = 32'd160;
  localparam logic [31:0] NUM_NDASH  = 32'd8211;
  localparam logic [31:0] NUM_MDASH  = 32'd8212;
  localparam logic [31:0] NUM_LSQUO  = 32'd8216;
  localparam logic [31:0] NUM_RSQUO  = 32'd8217;
  localparam logic [31:0] NUM_LDQUO  = 32'd8220;
  localparam logic [31:0] NUM_RDQUO  = 32'd8221;
  localparam logic [31:0] NUM_HELLIP = 32'd8230;
  localparam logic [31:0] NUM_PR_LO  = 32'd32;
  localparam logic [31:0] NUM_PR_HI  = 32'd126;

  // one queued command: literal bytes, window replay, tail byte, marker, done
  typedef struct packed {
    logic [LIT_MAX-1:0][7:0] lit;
    logic [1:0]              lit_n;
    logic [CNT_W-1:0]        rep_n;
    logic                    tail;
    logic [7:0]              tail_byte;
    logic                    marker;
    logic                    done;
  } cmd_t;

  // back to front: window read index and end of a replay
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             rep_done;
  } win_req_t;

  function automatic logic [LIT_MAX-1:0][7:0] pack3(input logic [7:0] b0,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2);
    logic [LIT_MAX-1:0][7:0] r;
    r[0] = b0;
    r[1] = b1;
    r[2] = b2;
    return r;
  endfunction

  function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] k,
                                           input logic [2:0] p);
    logic [47:0] s;
    case (k)
      5'd0:    s = {"nbsp", 16'h0};
      5'd1:    s = {"amp", 24'h0};
      5'd2:    s = {"lt", 32'h0};
      5'd3:    s = {"gt", 32'h0};
      5'd4:    s = {"quot", 16'h0};
      5'd5:    s = {"apos", 16'h0};
      5'd6:    s = {"copy", 16'h0};
      5'd7:    s = {"reg", 24'h0};
      5'd8:    s = {"mdash", 8'h0};
      5'd9:    s = {"ndash", 8'h0};
      5'd10:   s = {"laquo", 8'h0};
      5'd11:   s = {"raquo", 8'h0};
      5'd12:   s = {"ldquo", 8'h0};
      5'd13:   s = {"rdquo", 8'h0};
      5'd14:   s = {"lsquo", 8'h0};
      5'd15:   s = {"rsquo", 8'h0};
      5'd16:   s = "hellip";
      5'd17:   s = {"bull", 16'h0};
      5'd18:   s = "middot";
      5'd19:   s = {"trade", 8'h0};
      default: s = '0;
    endcase
    if (p > 3'd5) return 8'h00;
    return s[8*(5 - int'(p)) +: 8];
  endfunction

  function automatic logic [2:0] name_len(input logic [NAME_IDX_W-1:0] k);
    case (k)
      5'd0, 5'd4, 5'd5, 5'd6, 5'd17:           return 3'd4;
      5'd1, 5'd7:                              return 3'd3;
      5'd2, 5'd3:                              return 3'd2;
      5'd16, 5'd18:                            return 3'd6;
      default:                                 return 3'd5;
    endcase
  endfunction

  function automatic logic [1:0] rep_count(input logic [NAME_IDX_W-1:0] k);
    case (k)
      5'd6, 5'd7, 5'd16:           return 2'd3;
      5'd8, 5'd10, 5'd11, 5'd19:   return 2'd2;
      default:                     return 2'd1;
    endcase
  endfunction

  function automatic logic [LIT_MAX-1:0][7:0] rep_bytes(input logic [NAME_IDX_W-1:0] k);
    case (k)
      5'd0:    return pack3(" ", 8'h0, 8'h0);
      5'd1:    return pack3("&", 8'h0, 8'h0);
      5'd2:    return pack3("<", 8'h0, 8'h0);
      5'd3:    return pack3(">", 8'h0, 8'h0);
      5'd4:    return pack3(CH_QUOT, 8'h0, 8'h0);
      5'd5:    return pack3(CH_APOS, 8'h0, 8'h0);
      5'd6:    return pack3("(", "c", ")");
      5'd7:    return pack3("(", "R", ")");
      5'd8:    return pack3("-", "-", 8'h0);
      5'd9:    return pack3("-", 8'h0, 8'h0);
      5'd10:   return pack3("<", "<", 8'h0);
      5'd11:   return pack3(">", ">", 8'h0);
      5'd12:   return pack3(CH_QUOT, 8'h0, 8'h0);
      5'd13:   return pack3(CH_QUOT, 8'h0, 8'h0);
      5'd14:   return pack3(CH_APOS, 8'h0, 8'h0);
      5'd15:   return pack3(CH_APOS, 8'h0, 8'h0);
      5'd16:   return pack3(".", ".", ".");
      5'd17:   return pack3("*", 8'h0, 8'h0);
      5'd18:   return pack3(".", 8'h0, 8'h0);
      5'd19:   return pack3("T", "M", 8'h0);
      default: return pack3(8'h0, 8'h0, 8'h0);
    endcase
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'h0;
  endfunction

endpackage

>>> hw/rtl/hcrd_cmd_queue.sv
// small command queue between decoder front and emitter back
// depends on hcrd_pkg
module hcrd_cmd_queue
  import hcrd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic head_valid,
  output logic full
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;
  assign head       = mem_r[rd_ptr_r];
  assign head_valid = cnt_r != '0;
  assign full       = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);

  always_comb begin
    wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = (QPTR_W+1)'(cnt_r + {{QPTR_W{1'b0}}, do_push} - {{QPTR_W{1'b0}}, do_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/hcrd_front.sv
// decoder front: takes items, holds the reference window, decides references
// depends on hcrd_pkg; pushes commands into hcrd_cmd_queue
module hcrd_front
  import hcrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd,
  input  win_req_t   win_req,
  output logic [7:0] win_byte,
  output logic       busy
);

  logic                  in_ref_r, in_ref_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [7:0]            win_r [WINDOW_LEN];
  logic [NAME_COUNT-1:0] match_r, match_nxt;
  logic                  hash_r, hash_nxt;
  logic                  hex_r, hex_nxt;
  logic                  dstop_r, dstop_nxt;
  logic [31:0]           dec_v_r, dec_v_nxt;
  logic [31:0]           hex_v_r, hex_v_nxt;
  logic                  busy_r, busy_nxt;

  logic                  acc, semi, deciding, named, numeric, decoded, win_we;
  logic [NAME_COUNT-1:0] hit;
  logic [NAME_IDX_W-1:0] sel;
  logic [31:0]           val;
  cmd_t                  dcmd;
  logic [7:0]            c;

  assign c        = in_text_byte;
  assign in_ready = !q_full && !busy_r;
  assign acc      = in_valid && in_ready;
  assign busy     = busy_r;
  assign win_byte = win_r[win_req.idx];

  // decision from the scan state of the current reference
  always_comb begin
    semi     = !in_end_of_text && (c == CH_SEMI);
    deciding = in_ref_r && (c == CH_SEMI || c == CH_LT || c == CH_AMP ||
                            cnt_r >= CNT_W'(WINDOW_LEN));
    for (int k = 0; k < NAME_COUNT; k++) begin
      hit[k] = match_r[k] && (cnt_r >= CNT_W'(name_len(NAME_IDX_W'(k)))) &&
               (semi || cnt_r == CNT_W'(name_len(NAME_IDX_W'(k))));
    end
    sel = '0;
    for (int k = NAME_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) sel = NAME_IDX_W'(k);
    end
    named   = |hit;
    numeric = !named && hash_r;
    decoded = named || numeric;
    val     = hex_r ? hex_v_r : dec_v_r;

    dcmd = '0;
    if (named) begin
      dcmd.lit   = rep_bytes(sel);
      dcmd.lit_n = rep_count(sel);
    end else if (numeric) begin
      if (val == NUM_NBSP) begin
        dcmd.lit = pack3(CH_SPACE, 8'h0, 8'h0); dcmd.lit_n = 2'd1;
      end else if (val == NUM_NDASH || val == NUM_MDASH) begin
        dcmd.lit = pack3(CH_DASH, 8'h0, 8'h0); dcmd.lit_n = 2'd1;
      end else if (val == NUM_LSQUO || val == NUM_RSQUO) begin
        dcmd.lit = pack3(CH_APOS, 8'h0, 8'h0); dcmd.lit_n = 2'd1;
      end else if (val == NUM_LDQUO || val == NUM_RDQUO) begin
        dcmd.lit = pack3(CH_QUOT, 8'h0, 8'h0); dcmd.lit_n = 2'd1;
      end else if (val == NUM_HELLIP) begin
        dcmd.lit = pack3(CH_DOT, CH_DOT, CH_DOT); dcmd.lit_n = 2'd3;
      end else if (val >= NUM_PR_LO && val <= NUM_PR_HI) begin
        dcmd.lit = pack3(val[7:0], 8'h0, 8'h0); dcmd.lit_n = 2'd1;
      end
    end else begin
      dcmd.lit   = pack3(CH_AMP, 8'h0, 8'h0);
      dcmd.lit_n = 2'd1;
      dcmd.rep_n = cnt_r;
    end
  end

  // item handling
  always_comb begin
    in_ref_nxt = in_ref_r;
    cnt_nxt    = cnt_r;
    match_nxt  = match_r;
    hash_nxt   = hash_r;
    hex_nxt    = hex_r;
    dstop_nxt  = dstop_r;
    dec_v_nxt  = dec_v_r;
    hex_v_nxt  = hex_v_r;
    q_push     = 1'b0;
    q_cmd      = '0;
    win_we     = 1'b0;
    if (acc) begin
      if (in_end_of_text) begin
        if (in_ref_r) q_cmd = dcmd;
        q_cmd.marker = (q_cmd.lit_n == 2'd0);
        q_cmd.done   = 1'b1;
        q_push       = 1'b1;
        in_ref_nxt   = 1'b0;
        cnt_nxt      = '0;
      end else if (!in_ref_r || deciding) begin
        if (deciding) q_cmd = dcmd;
        q_cmd.tail      = !(deciding && decoded && semi) && (c != CH_AMP);
        q_cmd.tail_byte = c;
        if (!in_ref_r && c != CH_AMP) begin
          q_cmd.lit_n = 2'd0;
          q_cmd.rep_n = '0;
        end
        q_push     = (q_cmd.lit_n != 2'd0) || q_cmd.tail;
        in_ref_nxt = (c == CH_AMP);
        cnt_nxt    = '0;
        // fresh reference scan
        match_nxt  = '1;
        hash_nxt   = 1'b0;
        hex_nxt    = 1'b0;
        dstop_nxt  = 1'b0;
        dec_v_nxt  = '0;
        hex_v_nxt  = '0;
      end else begin
        win_we  = 1'b1;
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        for (int k = 0; k < NAME_COUNT; k++) begin
          if (cnt_r < CNT_W'(name_len(NAME_IDX_W'(k))) &&
              name_char(NAME_IDX_W'(k), cnt_r[2:0]) != c) begin
            match_nxt[k] = 1'b0;
          end
        end
        if (cnt_r == CNT_W'(0)) hash_nxt = (c == CH_HASH);
        if (cnt_r == CNT_W'(1)) hex_nxt = (c == CH_XL || c == CH_XU);
        if (cnt_r >= CNT_W'(1) && !dstop_r) begin
          if (c >= CH_0 && c <= CH_9) begin
            dec_v_nxt = {dec_v_r[28:0], 3'b000} + {dec_v_r[30:0], 1'b0} +
                        {24'h0, 8'(c - CH_0)};
          end else begin
            dstop_nxt = 1'b1;
          end
        end
        if (cnt_r >= CNT_W'(2)) hex_v_nxt = {hex_v_r[27:0], hex_nib(c)};
      end
    end
    // window is frozen while a replay reads it
    busy_nxt = busy_r;
    if (win_req.rep_done) busy_nxt = 1'b0;
    if (q_push && q_cmd.rep_n != '0) busy_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ref_r <= 1'b0;
      cnt_r    <= '0;
      busy_r   <= 1'b0;
      match_r  <= '1;
      hash_r   <= 1'b0;
      hex_r    <= 1'b0;
      dstop_r  <= 1'b0;
      dec_v_r  <= '0;
      hex_v_r  <= '0;
    end else begin
      in_ref_r <= in_ref_nxt;
      cnt_r    <= cnt_nxt;
      busy_r   <= busy_nxt;
      match_r  <= match_nxt;
      hash_r   <= hash_nxt;
      hex_r    <= hex_nxt;
      dstop_r  <= dstop_nxt;
      dec_v_r  <= dec_v_nxt;
      hex_v_r  <= hex_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_r[cnt_r[IDX_W-1:0]] <= c;
    end
  end

endmodule

>>> hw/rtl/hcrd_back.sv
// emitter back: walks each queued command and drives the result register
// depends on hcrd_pkg; reads the window held in hcrd_front
module hcrd_back
  import hcrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       q_head,
  input  logic       q_valid,
  output logic       q_pop,
  output win_req_t   win_req,
  input  logic [7:0] win_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_text_done
);

  cmd_t             cur_r;
  logic             cur_valid_r, cur_valid_nxt;
  logic [SEQ_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       byte_r;
  logic             bvalid_r, last_r, done_r;

  logic [SEQ_W-1:0] lit_end, rep_end, total;
  logic             last, out_ld, cur_load;
  logic [7:0]       sel_byte;
  logic             sel_valid;

  always_comb begin
    lit_end = SEQ_W'(cur_r.lit_n);
    rep_end = SEQ_W'(lit_end + SEQ_W'(cur_r.rep_n));
    total   = SEQ_W'(rep_end + SEQ_W'(cur_r.tail) + SEQ_W'(cur_r.marker));
    last    = (pos_r == SEQ_W'(total - 1'b1));
    out_ld  = cur_valid_r && (!out_valid_r || out_ready);
    cur_load = q_valid && (!cur_valid_r || (out_ld && last));

    win_req.idx      = IDX_W'(pos_r - lit_end);
    win_req.rep_done = out_ld && last && (cur_r.rep_n != '0);

    if (pos_r < lit_end) begin
      sel_byte  = cur_r.lit[pos_r[1:0]];
      sel_valid = 1'b1;
    end else if (pos_r < rep_end) begin
      sel_byte  = win_byte;
      sel_valid = 1'b1;
    end else if (cur_r.tail) begin
      sel_byte  = cur_r.tail_byte;
      sel_valid = 1'b1;
    end else begin
      sel_byte  = 8'h00;
      sel_valid = 1'b0;
    end

    cur_valid_nxt = cur_valid_r;
    pos_nxt       = pos_r;
    if (out_ld) begin
      pos_nxt = last ? '0 : SEQ_W'(pos_r + 1'b1);
      if (last) cur_valid_nxt = 1'b0;
    end
    if (cur_load) begin
      cur_valid_nxt = 1'b1;
      pos_nxt       = '0;
    end

    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (out_ld) out_valid_nxt = 1'b1;
  end

  assign q_pop          = cur_load;
  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_run_last   = last_r;
  assign out_text_done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur_r <= q_head;
    end
    if (out_ld) begin
      byte_r   <= sel_byte;
      bvalid_r <= sel_valid;
      last_r   <= last;
      done_r   <= last && cur_r.done;
    end
  end

endmodule

>>> hw/rtl/html_char_reference_decoder_top.sv
// a plain byte goes through the queue, the command register and the result register
// throughput: one plain-text item per cycle while out_ready holds, set by the emitter
// a window replay holds input until its command is out (up to 18 result bytes)
// reset: synchronous active-low rst_n clears the queue, the front and the output valid
// the window store needs no clearing; only bytes written in a reference are replayed
`include "html_char_reference_decoder_top_defines.svh"
module html_char_reference_decoder_top
  import hcrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_text_done
);

  // front to queue
  logic     q_push;
  cmd_t     q_cmd;
  logic     q_full;
  // queue to back
  cmd_t     q_head;
  logic     q_valid;
  logic     q_pop;
  // window read link, back to front and back
  win_req_t win_req;
  logic [7:0] win_byte;
  logic     front_busy;

  // front: classifies each item, keeps the reference window and scan state,
  // turns every item into at most one command
  hcrd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd),
    .win_req        (win_req),
    .win_byte       (win_byte),
    .busy           (front_busy)
  );

  // short queue so front and back stall apart
  hcrd_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  // back: expands a command into result items, one per cycle while out_ready allows
  hcrd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .win_req        (win_req),
    .win_byte       (win_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_text_done  (out_text_done)
  );

  // front never pushes into a full queue
  `HCRD_ASSERT(a_no_overflow, q_push |-> !q_full, "command queue overflow")
  // a replay can only end while the window is frozen
  `HCRD_ASSERT(a_replay_frozen, win_req.rep_done |-> front_busy, "replay end without freeze")
  // end of text is always the last result of its item
  `HCRD_ASSERT(a_done_last, (out_valid && out_text_done) |-> out_run_last, "text_done not last")
  // output valid drops right after reset
  `HCRD_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule
